@@ src/command_byte_stream_decoder_macros.svh @@
// Assertion macros shared by the decoder RTL.
// CBSD_ASSERT checks a property that is switched off while reset is asserted.
// CBSD_ASSERT_ALWAYS checks a property at every clock edge, reset included.
`ifndef COMMAND_BYTE_STREAM_DECODER_MACROS_SVH
`define COMMAND_BYTE_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define CBSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CBSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ src/cbsd_pkg.sv @@
package cbsd_pkg;

	// Opcode map of the command link.
	localparam logic [7:0] COMMAND_COUNT   = 8'd23;
	localparam logic [7:0] OP_KEY_PRESS    = 8'd1;
	localparam logic [7:0] OP_CONSOLE_TEXT = 8'd21;
	localparam logic [7:0] OP_TEXT_LENGTH  = 8'd22;

	// Default depth of the queue between the parser and the output stage.
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_FIRST = 2'd1,
		PH_MORE  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_KEY     = 2'd1,
		CMD_CONSOLE = 2'd2,
		CMD_LENGTH  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_KEY  = 2'd0,
		KIND_FONT = 2'd1,
		KIND_CHAR = 2'd2
	} kind_t;

	// One decoded event. For a key event arg0 is the key code and arg1 the
	// press type; otherwise arg1 carries the font length or the character.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] arg0;
		logic [7:0] arg1;
		logic       last;
	} event_t;

	// Handshake between the queue and its neighbors.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ src/cbsd_front.sv @@
`include "command_byte_stream_decoder_macros.svh"

module cbsd_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_ready,
	input  logic [7:0]              data_byte,
	input  cbsd_pkg::queue_status_t q_status,
	output logic                    push,
	output cbsd_pkg::event_t        push_event
);

	cbsd_pkg::phase_t phase_q, phase_d;
	cbsd_pkg::cmd_t   cmd_q, cmd_d;
	logic [7:0]       held_key_q, held_key_d;
	logic [7:0]       expected_q, expected_d;
	logic [7:0]       received_q, received_d;
	logic [7:0]       received_inc;
	logic             accept;
	cbsd_pkg::phase_t op_phase;
	cbsd_pkg::cmd_t   op_cmd;
	cbsd_pkg::phase_t phase_eff;

	// A byte is taken whenever the queue has room for a possible event.
	assign byte_ready = !q_status.full;
	assign accept     = byte_valid && byte_ready;

	assign received_inc = received_q + 8'd1;

	// A phase other than idle without a command is treated as idle.
	assign phase_eff = (cmd_q == cbsd_pkg::CMD_NONE) ? cbsd_pkg::PH_IDLE : phase_q;

	// Opcode classification. The range check comes first.
	always_comb begin
		op_phase = cbsd_pkg::PH_FIRST;
		op_cmd   = cbsd_pkg::CMD_NONE;
		if (data_byte >= cbsd_pkg::COMMAND_COUNT) begin
			op_phase = cbsd_pkg::PH_IDLE;
		end else if (data_byte == cbsd_pkg::OP_KEY_PRESS) begin
			op_cmd = cbsd_pkg::CMD_KEY;
		end else if (data_byte == cbsd_pkg::OP_CONSOLE_TEXT) begin
			op_cmd = cbsd_pkg::CMD_CONSOLE;
		end else if (data_byte == cbsd_pkg::OP_TEXT_LENGTH) begin
			op_cmd = cbsd_pkg::CMD_LENGTH;
		end else begin
			op_phase = cbsd_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cbsd_pkg::PH_IDLE;
			cmd_q      <= cbsd_pkg::CMD_NONE;
			held_key_q <= '0;
			expected_q <= '0;
			received_q <= '0;
		end else begin
			phase_q    <= phase_d;
			cmd_q      <= cmd_d;
			held_key_q <= held_key_d;
			expected_q <= expected_d;
			received_q <= received_d;
		end
	end

	always_comb begin
		phase_d         = phase_q;
		cmd_d           = cmd_q;
		held_key_d      = held_key_q;
		expected_d      = expected_q;
		received_d      = received_q;
		push            = 1'b0;
		push_event.kind = cbsd_pkg::KIND_KEY;
		push_event.arg0 = held_key_q;
		push_event.arg1 = data_byte;
		push_event.last = 1'b0;
		if (accept) begin
			unique case (phase_eff)
				cbsd_pkg::PH_FIRST: begin
					unique case (cmd_q)
						cbsd_pkg::CMD_KEY: begin
							held_key_d = data_byte;
							phase_d    = cbsd_pkg::PH_MORE;
						end
						cbsd_pkg::CMD_LENGTH: begin
							push            = 1'b1;
							push_event.kind = cbsd_pkg::KIND_FONT;
							phase_d         = cbsd_pkg::PH_IDLE;
							cmd_d           = cbsd_pkg::CMD_NONE;
						end
						cbsd_pkg::CMD_CONSOLE: begin
							expected_d = data_byte;
							received_d = '0;
							if (data_byte == 8'd0) begin
								phase_d = cbsd_pkg::PH_IDLE;
								cmd_d   = cbsd_pkg::CMD_NONE;
							end else begin
								phase_d = cbsd_pkg::PH_MORE;
							end
						end
						default: begin
							phase_d = cbsd_pkg::PH_IDLE;
							cmd_d   = cbsd_pkg::CMD_NONE;
						end
					endcase
				end
				cbsd_pkg::PH_MORE: begin
					unique case (cmd_q)
						cbsd_pkg::CMD_KEY: begin
							push    = 1'b1;
							phase_d = cbsd_pkg::PH_IDLE;
							cmd_d   = cbsd_pkg::CMD_NONE;
						end
						cbsd_pkg::CMD_CONSOLE: begin
							push            = 1'b1;
							push_event.kind = cbsd_pkg::KIND_CHAR;
							push_event.last = (received_inc == expected_q);
							received_d      = received_inc;
							if (received_inc == expected_q) begin
								phase_d = cbsd_pkg::PH_IDLE;
								cmd_d   = cbsd_pkg::CMD_NONE;
							end
						end
						default: begin
							phase_d = cbsd_pkg::PH_IDLE;
							cmd_d   = cbsd_pkg::CMD_NONE;
						end
					endcase
				end
				default: begin
					// Idle, or an unreachable phase: the byte is an opcode.
					phase_d = op_phase;
					cmd_d   = op_cmd;
				end
			endcase
		end
	end

	`CBSD_ASSERT(a_more_has_args, clk, arst_n, (phase_q == cbsd_pkg::PH_MORE) |-> (cmd_q == cbsd_pkg::CMD_KEY || cmd_q == cbsd_pkg::CMD_CONSOLE), "argument phase entered by a command without further arguments")
	`CBSD_ASSERT(a_console_len, clk, arst_n, (phase_q == cbsd_pkg::PH_MORE && cmd_q == cbsd_pkg::CMD_CONSOLE) |-> (expected_q != 8'd0 && received_q != expected_q), "console text running with no characters left")

endmodule

@@ src/cbsd_queue.sv @@
`include "command_byte_stream_decoder_macros.svh"

module cbsd_queue #(
	parameter int DEPTH = cbsd_pkg::QUEUE_DEPTH
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  cbsd_pkg::event_t        push_event,
	input  logic                    pop,
	output cbsd_pkg::event_t        head_event,
	output cbsd_pkg::queue_status_t status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	cbsd_pkg::event_t slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign status.full  = (count_q == FULL_CNT);
	assign status.empty = (count_q == '0);
	assign head_event   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_event;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`CBSD_ASSERT(a_count_range, clk, arst_n, count_q <= FULL_CNT, "queue fill count beyond depth")
	`CBSD_ASSERT(a_no_overflow, clk, arst_n, push |-> !status.full, "event written into a full queue")
	`CBSD_ASSERT(a_no_underflow, clk, arst_n, pop |-> !status.empty, "event read from an empty queue")

endmodule

@@ src/cbsd_back.sv @@
`include "command_byte_stream_decoder_macros.svh"

module cbsd_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cbsd_pkg::queue_status_t q_status,
	input  cbsd_pkg::event_t        head_event,
	output logic                    pop,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [31:0]             m_axis_tdata,
	output logic [1:0]              m_axis_tuser,
	output logic                    m_axis_tlast
);

	logic        valid_q;
	logic [31:0] tdata_q;
	logic [1:0]  tuser_q;
	logic        tlast_q;
	logic [31:0] tdata_d;
	logic        tlast_d;

	// The output register refills in the cycle its word is taken.
	assign pop = !q_status.empty && (!valid_q || m_axis_tready);

	// Fields that do not belong to the event kind are sent as zero.
	always_comb begin
		tdata_d = '0;
		tlast_d = 1'b0;
		unique case (head_event.kind)
			cbsd_pkg::KIND_KEY: begin
				tdata_d[7:0]  = head_event.arg0;
				tdata_d[15:8] = head_event.arg1;
			end
			cbsd_pkg::KIND_FONT: begin
				tdata_d[23:16] = head_event.arg1;
			end
			cbsd_pkg::KIND_CHAR: begin
				tdata_d[31:24] = head_event.arg1;
				tlast_d        = head_event.last;
			end
			default: begin
				tdata_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			tdata_q <= tdata_d;
			tuser_q <= head_event.kind;
			tlast_q <= tlast_d;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

	`CBSD_ASSERT(a_last_only_char, clk, arst_n, (valid_q && tlast_q) |-> (tuser_q == cbsd_pkg::KIND_CHAR), "end of text marked on an event that is not a character")

endmodule

@@ src/command_byte_stream_decoder.sv @@
// Channel   | Signals                        | Carries
// ----------+--------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata[7:0]       | one link byte (opcode or argument)
// m_axis    | tvalid tready tdata tuser tlast| one decoded event (key, font length, char)
//
// A byte is taken in every cycle while the event queue has room, one byte per cycle.
// The parser decodes a byte in its accepting cycle and writes any event into the queue
// at that edge; the output stage later loads it into the register that drives m_axis_tvalid.
// The queue of QUEUE_DEPTH entries plus the output register absorb output stalls, and
// s_axis_tready falls only while the queue is full.
// arst_n clears the parser to idle and empties the queue and output register.
`include "command_byte_stream_decoder_macros.svh"

module command_byte_stream_decoder #(
	parameter int QUEUE_DEPTH = cbsd_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] key_code, [15:8] press_type, [23:16] font_length, [31:24] console_char
	output logic [31:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [1:0] kind
	output logic        m_axis_tlast   // last_char
);

	cbsd_pkg::queue_status_t q_status;
	cbsd_pkg::event_t        push_event;
	cbsd_pkg::event_t        head_event;
	logic                    push;
	logic                    pop;

	// The parser tracks the command in progress and writes one event into the
	// queue for each key press, font length and console character.
	cbsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_axis_tvalid),
		.byte_ready (s_axis_tready),
		.data_byte  (s_axis_tdata),
		.q_status   (q_status),
		.push       (push),
		.push_event (push_event)
	);

	// The queue decouples parsing from output stalls.
	cbsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_event (push_event),
		.pop        (pop),
		.head_event (head_event),
		.status     (q_status)
	);

	// The output stage formats each event into the stream word and holds it
	// until the transfer completes.
	cbsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_status      (q_status),
		.head_event    (head_event),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// When the queue is empty and the output register is free, nothing stalls
	// the input side.
	`CBSD_ASSERT(a_ready_when_empty, clk, arst_n, q_status.empty |-> s_axis_tready, "input stalled with an empty queue")

endmodule

@@ dv/cbsd_event_checker.sv @@
// Watches both channels of the decoder, works out the event that each
// accepted link byte should produce and compares every event leaving m_axis
// against the oldest one still outstanding.
module cbsd_event_checker
	import cbsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          events_outstanding
);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] key_code;
		logic [7:0] press_type;
		logic [7:0] font_length;
		logic [7:0] console_char;
		logic       last_char;
	} link_event_t;

	phase_t      phase;
	cmd_t        command;
	logic [7:0]  held_key;
	logic [7:0]  char_total;
	logic [7:0]  chars_seen;
	link_event_t event_queue[$];

	initial fail_count = 0;
	assign events_outstanding = event_queue.size();

	function automatic void end_command();
		phase   = PH_IDLE;
		command = CMD_NONE;
	endfunction

	// Advances the decoder state by one link byte and queues the event it causes.
	function automatic void decode_link_byte(input logic [7:0] b);
		link_event_t ev;
		ev = '0;
		if (!(phase inside {PH_FIRST, PH_MORE}) || command == CMD_NONE)
			end_command();
		case (phase)
			PH_FIRST: begin
				case (command)
					CMD_KEY: begin
						held_key = b;
						phase    = PH_MORE;
					end
					CMD_LENGTH: begin
						ev.kind        = KIND_FONT;
						ev.font_length = b;
						event_queue.push_back(ev);
						end_command();
					end
					default: begin
						char_total = b;
						chars_seen = 8'd0;
						if (b == 8'd0)
							end_command();
						else
							phase = PH_MORE;
					end
				endcase
			end
			PH_MORE: begin
				case (command)
					CMD_KEY: begin
						ev.kind       = KIND_KEY;
						ev.key_code   = held_key;
						ev.press_type = b;
						event_queue.push_back(ev);
						end_command();
					end
					CMD_CONSOLE: begin
						chars_seen      = chars_seen + 8'd1;
						ev.kind         = KIND_CHAR;
						ev.console_char = b;
						ev.last_char    = (chars_seen == char_total);
						event_queue.push_back(ev);
						if (ev.last_char)
							end_command();
					end
					default: end_command();
				endcase
			end
			default: begin
				// Opcode range check comes first, so nothing at or above the
				// command count is ever recognized.
				if (b >= COMMAND_COUNT) begin
					end_command();
				end else if (b == OP_KEY_PRESS) begin
					command = CMD_KEY;
					phase   = PH_FIRST;
				end else if (b == OP_CONSOLE_TEXT) begin
					command = CMD_CONSOLE;
					phase   = PH_FIRST;
				end else if (b == OP_TEXT_LENGTH) begin
					command = CMD_LENGTH;
					phase   = PH_FIRST;
				end else begin
					end_command();
				end
			end
		endcase
	endfunction

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		link_event_t want;
		if (!arst_n) begin
			phase      = PH_IDLE;
			command    = CMD_NONE;
			held_key   = 8'd0;
			char_total = 8'd0;
			chars_seen = 8'd0;
			event_queue.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				decode_link_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (event_queue.size() == 0) begin
					$error("unexpected event: kind %0d, data %h, last %0d",
						m_axis_tuser, m_axis_tdata, m_axis_tlast);
					fail_count++;
				end else begin
					want = event_queue.pop_front();
					compare_field("kind", want.kind, m_axis_tuser);
					compare_field("key_code", want.key_code, m_axis_tdata[7:0]);
					compare_field("press_type", want.press_type, m_axis_tdata[15:8]);
					compare_field("font_length", want.font_length, m_axis_tdata[23:16]);
					compare_field("console_char", want.console_char, m_axis_tdata[31:24]);
					compare_field("last_char", want.last_char, m_axis_tlast);
				end
			end
		end
	end

endmodule

@@ dv/tb_command_byte_stream_decoder.sv @@
// Top of the decoder testbench. It builds the link byte stream, feeds it in
// bursts, throttles the event side and gives the verdict. All prediction and
// comparison lives in the checker instantiated next to the block.
module tb_command_byte_stream_decoder;
	import cbsd_pkg::*;

	// Cycles without any transfer on either channel before the run is declared hung.
	// The longest legitimate quiet stretch is the receiver hold-off below.
	localparam int STALL_LIMIT = 2000;
	// Cycles to keep watching for stray events once nothing is outstanding.
	localparam int DRAIN_CYCLES = 12;
	// Random link bytes wanted, not counting opcodes the decoder simply drops.
	localparam int RANDOM_ITEMS = 1100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'd0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	int fail_count;
	int events_outstanding;
	int stall_cycles = 0;

	// The whole link stream is laid out before reset is released.
	logic [7:0] link_bytes[$];
	int         counted_items;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	command_byte_stream_decoder uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	cbsd_event_checker u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_axis_tvalid     (s_axis_tvalid),
		.s_axis_tready     (s_axis_tready),
		.s_axis_tdata      (s_axis_tdata),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.m_axis_tuser      (m_axis_tuser),
		.m_axis_tlast      (m_axis_tlast),
		.fail_count        (fail_count),
		.events_outstanding(events_outstanding)
	);

	// Appends one link byte; bytes the decoder drops outright are not counted.
	function automatic void add_byte(input logic [7:0] b, input bit counts = 1'b1);
		link_bytes.push_back(b);
		if (counts)
			counted_items++;
	endfunction

	// A console command: opcode, length byte, then that many random characters.
	function automatic void add_console(input logic [7:0] len);
		add_byte(OP_CONSOLE_TEXT);
		add_byte(len);
		for (int i = 0; i < len; i++)
			add_byte(8'($urandom_range(0, 255)));
	endfunction

	// Short directed opening: field extremes, every opcode class and the
	// corner cases of the console length.
	function automatic void build_directed();
		// Key events with key code and press type at both extremes.
		add_byte(OP_KEY_PRESS); add_byte(8'h00); add_byte(8'hFF);
		add_byte(OP_KEY_PRESS); add_byte(8'hFF); add_byte(8'h00);
		// Font length at both extremes.
		add_byte(OP_TEXT_LENGTH); add_byte(8'hFF);
		add_byte(OP_TEXT_LENGTH); add_byte(8'h00);
		// A zero console length ends the command at the length byte.
		add_byte(OP_CONSOLE_TEXT); add_byte(8'h00);
		// Single character, then two, with the last marker on the final one of each.
		add_byte(OP_CONSOLE_TEXT); add_byte(8'h01); add_byte(8'hA5);
		add_byte(OP_CONSOLE_TEXT); add_byte(8'h02); add_byte(8'h5A); add_byte(8'hFF);
		// Dropped opcode 0, text length taking COMMAND_COUNT as argument, then 8'hFF.
		add_byte(8'd0, 1'b0); add_byte(COMMAND_COUNT - 8'd1, 1'b0);
		add_byte(COMMAND_COUNT, 1'b0); add_byte(8'hFF, 1'b0);
		// Argument bytes that look like opcodes are still plain arguments.
		add_byte(OP_KEY_PRESS); add_byte(OP_CONSOLE_TEXT); add_byte(OP_TEXT_LENGTH);
	endfunction

	// Random part: mostly well-formed commands with random content, with
	// some ignored opcodes and raw noise mixed in. One console text of the
	// full 255 characters is placed partway through.
	function automatic void build_random();
		int unsigned pick;
		bit          full_console_done;
		logic [7:0]  op;
		full_console_done = 1'b0;
		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (!full_console_done && counted_items > RANDOM_ITEMS / 2) begin
				add_console(8'd255);
				full_console_done = 1'b1;
			end else if (pick < 28) begin
				add_byte(OP_KEY_PRESS);
				add_byte(8'($urandom_range(0, 255)));
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 43) begin
				add_byte(OP_TEXT_LENGTH);
				add_byte(8'($urandom_range(0, 255)));
			end else if (pick < 72) begin
				// Mostly short texts, a few empty ones and the odd long one.
				pick = $urandom_range(0, 99);
				if (pick < 5)
					add_console(8'd0);
				else if (pick < 8)
					add_console(8'($urandom_range(9, 255)));
				else
					add_console(8'($urandom_range(1, 8)));
			end else if (pick < 82) begin
				do
					op = 8'($urandom_range(0, COMMAND_COUNT - 1));
				while (op == OP_KEY_PRESS || op == OP_CONSOLE_TEXT ||
					op == OP_TEXT_LENGTH);
				add_byte(op, 1'b0);
			end else if (pick < 90) begin
				add_byte(8'($urandom_range(COMMAND_COUNT, 255)), 1'b0);
			end else begin
				// Raw noise: may cut a command short or start one by accident.
				repeat ($urandom_range(1, 3))
					add_byte(8'($urandom_range(0, 255)));
			end
		end
	endfunction

	// Sender: bursts of random length separated by random gaps. A byte is
	// held until its transfer completes; within a burst tvalid simply stays
	// high from one byte to the next.
	initial begin : link_sender
		int unsigned idx;
		int unsigned burst_len;
		int unsigned gap_len;
		counted_items = 0;
		build_directed();
		build_random();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		idx = 0;
		while (idx < link_bytes.size()) begin
			// Occasional long bursts give stretches with no idling at all.
			if ($urandom_range(0, 7) == 0)
				burst_len = $urandom_range(40, 160);
			else
				burst_len = $urandom_range(1, 16);
			while (burst_len != 0 && idx < link_bytes.size()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= link_bytes[idx];
				do
					@(posedge clk);
				while (!s_axis_tready);
				idx++;
				burst_len--;
			end
			gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap_len != 0 || idx == link_bytes.size()) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		// Every byte is in; wait for the last events, then watch a little
		// longer for anything the decoder should not have produced.
		do
			@(negedge clk);
		while (events_outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: it switches at random between readiness patterns: always
	// ready, coin flip, one cycle in four and mostly ready. Two long
	// hold-offs let the event queue fill so that s_axis_tready has to drop
	// while the sender keeps offering bytes.
	initial begin : event_sink
		int unsigned cycle_count;
		int unsigned mode;
		cycle_count = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count % 256 == 0)
				mode = $urandom_range(0, 3);
			if ((cycle_count >= 300 && cycle_count < 500) ||
				(cycle_count >= 1200 && cycle_count < 1320)) begin
				m_axis_tready <= 1'b0;
			end else begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cycle_count % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Watchdog: a run in which neither channel completes a transfer until the
	// stall count reaches STALL_LIMIT is hung.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

@@ filelist.f @@
+incdir+src
src/cbsd_pkg.sv
src/cbsd_front.sv
src/cbsd_queue.sv
src/cbsd_back.sv
src/command_byte_stream_decoder.sv
dv/cbsd_event_checker.sv
dv/tb_command_byte_stream_decoder.sv
